// File: rtl/dcl_pkg.sv
`timescale 1ns / 1ps

package dcl_pkg;

  localparam int NUM_BINS    = 4096;
  localparam int MAX_CHOICES = 4;
  localparam int LOAD_BITS   = 16;

  // fixed field widths of the channels
  localparam int IDX_W          = 12;
  localparam int LOAD_FIELD_W   = 16;
  localparam int BIN_COUNT_W    = 13;
  localparam int CHOICE_COUNT_W = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int FIELD_CHOICES  = 4;

  localparam int CAND_N = (MAX_CHOICES > FIELD_CHOICES) ? MAX_CHOICES : FIELD_CHOICES;
  localparam int CNT_W  = $clog2(CAND_N + 1);
  localparam int RP_W   = (MAX_CHOICES > 1) ? $clog2(MAX_CHOICES) : 1;
  localparam int FILL_W = $clog2(MAX_CHOICES + 1);
  localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [LOAD_BITS-1:0] load_t;

  typedef enum logic {
    ACT_INSERT,
    ACT_READ
  } action_e;

  typedef enum logic [1:0] {
    STAT_PLACED,
    STAT_PRIMING,
    STAT_READ,
    STAT_RANGE
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_COUNT    = 2'd0,
    CFG_CHOICE_COUNT = 2'd1,
    CFG_STREAM_MODE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLAN_DIRECT,
    PLAN_READ,
    PLAN_PLACE
  } plan_e;

  typedef enum logic [2:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_READ,
    SEQ_LAST,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    action_e action;
    idx_t    choice_0;
    idx_t    choice_1;
    idx_t    choice_2;
    idx_t    choice_3;
    idx_t    read_index;
  } item_t;

  typedef struct packed {
    status_e                 status;
    idx_t                    bin_index;
    logic [LOAD_FIELD_W-1:0] load;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic [BIN_COUNT_W-1:0]    bin_count;
    logic [CHOICE_COUNT_W-1:0] choice_count;
    logic                      stream_mode;
  } cfg_t;

  // what the front end decided for the offered item
  typedef struct packed {
    plan_e                  kind;
    status_e                status;
    idx_t                   bin_index;
    idx_t [CAND_N-1:0]      cand;
    logic [CNT_W-1:0]       count;
  } plan_t;

  typedef struct packed {
    logic              we;
    logic [BIN_AW-1:0] waddr;
    load_t             wdata;
    logic              re;
    logic [BIN_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic in_range(idx_t idx, logic [BIN_COUNT_W-1:0] bin_count);
    return (32'(idx) < 32'(bin_count)) && (32'(idx) < 32'(NUM_BINS));
  endfunction

  function automatic logic [CNT_W-1:0] clamp_choices(logic [CHOICE_COUNT_W-1:0] cc);
    logic [CNT_W-1:0] d;
    if (cc == '0) begin
      d = CNT_W'(1);
    end else if (32'(cc) > 32'(MAX_CHOICES)) begin
      d = CNT_W'(MAX_CHOICES);
    end else begin
      d = CNT_W'(cc);
    end
    return d;
  endfunction

endpackage

// File: rtl/dcl_if.sv
`timescale 1ns / 1ps

interface dcl_in_if;
  logic            valid;
  logic            ready;
  dcl_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcl_out_if;
  logic             valid;
  logic             ready;
  dcl_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dcl_pkg::CFG_IDX_W-1:0]    index;
  logic [dcl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/d_choice_least_loaded_insert.sv
`timescale 1ns / 1ps

// channel   dir  transfer when        payload
// in_i      in   valid & ready        action, choice_0..choice_3, read_index
// out_o     out  valid & ready        status, bin_index, load, saturated
// cfg_i     in   valid & ready        index, data (bin_count, choice_count, stream_mode)
//
// an insert that places a ball goes through accept, d load reads from the
// single-read-port load table, then compare and write-back; a read goes through
// accept, one load read and its result; an error or priming result goes straight
// from accept to its result; after reset a clearing pass zeroes all NUM_BINS
// entries of the table with in_i.ready low; configuration writes are taken during it
// the result sits in an output register, so the next item is taken while it waits;
// the block stalls only when a new result is ready and the previous one is still held

module d_choice_least_loaded_insert (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcl_in_if.sink        in_i,
  dcl_out_if.source     out_o,
  dcl_cfg_if.sink       cfg_i
);

  dcl_pkg::cfg_t     cfg_q;
  logic              ring_clear;
  logic              accept;
  dcl_pkg::plan_t    plan;
  dcl_pkg::ram_req_t ram_req;
  dcl_pkg::load_t    ram_rdata;

  assign cfg_i.ready = 1'b1;
  assign ring_clear  = cfg_i.valid &&
                       (cfg_i.index == dcl_pkg::CFG_CHOICE_COUNT ||
                        cfg_i.index == dcl_pkg::CFG_STREAM_MODE);
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_count    <= dcl_pkg::BIN_COUNT_W'(4096);
      cfg_q.choice_count <= dcl_pkg::CHOICE_COUNT_W'(2);
      cfg_q.stream_mode  <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == dcl_pkg::CFG_BIN_COUNT) begin
        cfg_q.bin_count <= cfg_i.data[dcl_pkg::BIN_COUNT_W-1:0];
      end
      if (cfg_i.index == dcl_pkg::CFG_CHOICE_COUNT) begin
        cfg_q.choice_count <= cfg_i.data[dcl_pkg::CHOICE_COUNT_W-1:0];
      end
      if (cfg_i.index == dcl_pkg::CFG_STREAM_MODE) begin
        cfg_q.stream_mode <= cfg_i.data[0];
      end
    end
  end

  dcl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (in_i.data),
    .take_i       (accept),
    .cfg_i        (cfg_q),
    .ring_clear_i (ring_clear),
    .plan_o       (plan)
  );

  dcl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .plan_i      (plan),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  dcl_ram #(
    .Depth (dcl_pkg::NUM_BINS),
    .Width (dcl_pkg::LOAD_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.we),
    .wr_addr_i (ram_req.waddr),
    .wr_data_i (ram_req.wdata),
    .rd_en_i   (ram_req.re),
    .rd_addr_i (ram_req.raddr),
    .rd_data_o (ram_rdata)
  );

endmodule

// File: rtl/dcl_ram.sv
`timescale 1ns / 1ps

module dcl_ram #(
  parameter int Depth = 2,
  parameter int Width = 8
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                      rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: rtl/dcl_front.sv
`timescale 1ns / 1ps

module dcl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dcl_pkg::item_t  item_i,
  input  logic            take_i,
  input  dcl_pkg::cfg_t   cfg_i,
  input  logic            ring_clear_i,
  output dcl_pkg::plan_t  plan_o
);

  dcl_pkg::idx_t              ring_q [dcl_pkg::MAX_CHOICES];
  dcl_pkg::idx_t              ring_nx [dcl_pkg::MAX_CHOICES];
  logic [dcl_pkg::RP_W-1:0]   rp_q, rp_d;
  logic [dcl_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                       ring_we;

  always_comb begin
    logic [dcl_pkg::CNT_W-1:0] d_all;
    logic [dcl_pkg::CNT_W-1:0] d_fresh;
    dcl_pkg::idx_t             fields [dcl_pkg::FIELD_CHOICES];
    dcl_pkg::idx_t             bad_idx;
    logic                      bad;
    logic [dcl_pkg::RP_W-1:0]  rp_eff;

    d_all   = dcl_pkg::clamp_choices(cfg_i.choice_count);
    d_fresh = (32'(d_all) > 32'(dcl_pkg::FIELD_CHOICES)) ?
              dcl_pkg::CNT_W'(dcl_pkg::FIELD_CHOICES) : d_all;
    fields[0] = item_i.choice_0;
    fields[1] = item_i.choice_1;
    fields[2] = item_i.choice_2;
    fields[3] = item_i.choice_3;
    bad       = 1'b0;
    bad_idx   = '0;
    rp_eff    = '0;

    ring_nx          = ring_q;
    rp_d             = rp_q;
    fill_d           = fill_q;
    ring_we          = 1'b0;
    plan_o.kind      = dcl_pkg::PLAN_DIRECT;
    plan_o.status    = dcl_pkg::STAT_RANGE;
    plan_o.bin_index = '0;
    plan_o.cand      = '0;
    plan_o.count     = d_all;

    if (item_i.action == dcl_pkg::ACT_READ) begin
      plan_o.bin_index = item_i.read_index;
      if (dcl_pkg::in_range(item_i.read_index, cfg_i.bin_count)) begin
        plan_o.kind    = dcl_pkg::PLAN_READ;
        plan_o.cand[0] = item_i.read_index;
        plan_o.count   = dcl_pkg::CNT_W'(1);
      end
    end else if (!cfg_i.stream_mode) begin
      for (int i = 0; i < dcl_pkg::FIELD_CHOICES; i++) begin
        if (32'(i) < 32'(d_fresh) && !bad && !dcl_pkg::in_range(fields[i], cfg_i.bin_count)) begin
          bad     = 1'b1;
          bad_idx = fields[i];
        end
        plan_o.cand[i] = fields[i];
      end
      if (bad) begin
        plan_o.bin_index = bad_idx;
      end else begin
        plan_o.kind  = dcl_pkg::PLAN_PLACE;
        plan_o.count = d_fresh;
      end
    end else begin
      plan_o.bin_index = item_i.choice_0;
      if (dcl_pkg::in_range(item_i.choice_0, cfg_i.bin_count)) begin
        ring_we         = 1'b1;
        rp_eff          = (32'(rp_q) >= 32'(d_all)) ? '0 : rp_q;
        ring_nx[rp_eff] = item_i.choice_0;
        rp_d            = (32'(rp_eff) + 32'd1 >= 32'(d_all)) ? '0 : rp_eff + 1'b1;
        fill_d          = (32'(fill_q) < 32'(dcl_pkg::MAX_CHOICES)) ? fill_q + 1'b1 : fill_q;
        if (32'(fill_d) < 32'(d_all)) begin
          plan_o.status = dcl_pkg::STAT_PRIMING;
        end else begin
          // entries may predate a shrink of the bin count
          for (int i = 0; i < dcl_pkg::MAX_CHOICES; i++) begin
            if (32'(i) < 32'(d_all) && !bad && !dcl_pkg::in_range(ring_nx[i], cfg_i.bin_count)) begin
              bad     = 1'b1;
              bad_idx = ring_nx[i];
            end
            plan_o.cand[i] = ring_nx[i];
          end
          if (bad) begin
            plan_o.bin_index = bad_idx;
          end else begin
            plan_o.kind = dcl_pkg::PLAN_PLACE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      fill_q <= '0;
    end else if (ring_clear_i) begin
      rp_q   <= '0;
      fill_q <= '0;
    end else if (take_i && ring_we) begin
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && ring_we) begin
      ring_q <= ring_nx;
    end
  end

endmodule

// File: rtl/dcl_seq.sv
`timescale 1ns / 1ps

module dcl_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dcl_pkg::plan_t                 plan_i,
  output dcl_pkg::ram_req_t              ram_req_o,
  input  dcl_pkg::load_t                 ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dcl_pkg::result_t               out_data_o
);

  dcl_pkg::seq_state_e         state_q, state_d;
  logic [dcl_pkg::BIN_AW-1:0]  clr_q, clr_d;
  logic [dcl_pkg::CNT_W-1:0]   k_q, k_d;
  logic                        out_valid_q, out_valid_d;

  dcl_pkg::plan_e              kind_q;
  dcl_pkg::idx_t [dcl_pkg::CAND_N-1:0] cand_q;
  logic [dcl_pkg::CNT_W-1:0]   n_q;
  dcl_pkg::result_t            res_q;
  dcl_pkg::result_t            out_q;
  dcl_pkg::idx_t               rd_idx_q;
  dcl_pkg::idx_t               best_idx_q;
  dcl_pkg::load_t              best_load_q;

  logic                        out_free;
  logic                        out_load;
  logic                        accept;
  logic                        lt;
  logic                        fin_take;
  dcl_pkg::idx_t               fin_idx;
  dcl_pkg::load_t              fin_load;
  logic                        fin_sat;
  dcl_pkg::load_t              new_load;
  logic                        last_issue;
  dcl_pkg::result_t            fin_res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == dcl_pkg::SEQ_LAST || state_q == dcl_pkg::SEQ_DONE) && out_free;
  assign last_issue = (32'(k_q) + 32'd1 >= 32'(n_q));

  // compare the returning load against the best so far; slot order wins ties
  assign lt       = ram_rdata_i < best_load_q;
  assign fin_take = (n_q == dcl_pkg::CNT_W'(1)) || lt;
  assign fin_idx  = fin_take ? rd_idx_q : best_idx_q;
  assign fin_load = fin_take ? ram_rdata_i : best_load_q;
  assign fin_sat  = (fin_load == dcl_pkg::LOAD_MAX);
  assign new_load = fin_sat ? fin_load : fin_load + 1'b1;

  always_comb begin
    if (kind_q == dcl_pkg::PLAN_READ) begin
      fin_res.status    = dcl_pkg::STAT_READ;
      fin_res.bin_index = rd_idx_q;
      fin_res.load      = dcl_pkg::LOAD_FIELD_W'(ram_rdata_i);
      fin_res.saturated = 1'b0;
    end else begin
      fin_res.status    = dcl_pkg::STAT_PLACED;
      fin_res.bin_index = fin_idx;
      fin_res.load      = dcl_pkg::LOAD_FIELD_W'(new_load);
      fin_res.saturated = fin_sat;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcl_pkg::SEQ_CLEAR: begin
        if (clr_q == dcl_pkg::BIN_AW'(dcl_pkg::NUM_BINS - 1)) state_d = dcl_pkg::SEQ_IDLE;
      end
      dcl_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = (plan_i.kind == dcl_pkg::PLAN_DIRECT) ? dcl_pkg::SEQ_DONE : dcl_pkg::SEQ_READ;
        end
      end
      dcl_pkg::SEQ_READ: begin
        if (last_issue) state_d = dcl_pkg::SEQ_LAST;
      end
      dcl_pkg::SEQ_LAST,
      dcl_pkg::SEQ_DONE: begin
        if (out_free) state_d = dcl_pkg::SEQ_IDLE;
      end
      default: state_d = dcl_pkg::SEQ_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o      = 1'b0;
    ram_req_o       = '0;
    clr_d           = clr_q;
    k_d             = k_q;
    unique case (state_q)
      dcl_pkg::SEQ_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        clr_d           = clr_q + 1'b1;
      end
      dcl_pkg::SEQ_IDLE: begin
        in_ready_o = 1'b1;
        k_d        = '0;
      end
      dcl_pkg::SEQ_READ: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = dcl_pkg::BIN_AW'(cand_q[0]);
        k_d             = k_q + 1'b1;
      end
      dcl_pkg::SEQ_LAST: begin
        // write-back lands before the next item can issue a read
        if (out_free && kind_q == dcl_pkg::PLAN_PLACE && !fin_sat) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = dcl_pkg::BIN_AW'(fin_idx);
          ram_req_o.wdata = new_load;
        end
      end
      dcl_pkg::SEQ_DONE: begin
        k_d = '0;
      end
      default: begin
        k_d = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcl_pkg::SEQ_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q            <= plan_i.kind;
      cand_q            <= plan_i.cand;
      n_q               <= plan_i.count;
      res_q.status      <= plan_i.status;
      res_q.bin_index   <= plan_i.bin_index;
      res_q.load        <= '0;
      res_q.saturated   <= 1'b0;
    end else if (state_q == dcl_pkg::SEQ_READ) begin
      // candidates shift toward slot zero as they are issued
      for (int i = 0; i < dcl_pkg::CAND_N - 1; i++) begin
        cand_q[i] <= cand_q[i+1];
      end
      rd_idx_q <= cand_q[0];
      if (k_q != '0 && (k_q == dcl_pkg::CNT_W'(1) || lt)) begin
        best_idx_q  <= rd_idx_q;
        best_load_q <= ram_rdata_i;
      end
    end
    if (out_load) begin
      out_q <= (state_q == dcl_pkg::SEQ_DONE) ? res_q : fin_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dcl_checker.sv
`timescale 1ns / 1ps

module dcl_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input dcl_pkg::result_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on two cycles in a row");

  a_no_load_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == dcl_pkg::STAT_PRIMING ||
                    out_data_i.status == dcl_pkg::STAT_RANGE)
    |-> out_data_i.load == '0 && !out_data_i.saturated)
    else $error("priming or range result carries a load");

  a_sat_only_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.saturated
    |-> out_data_i.status == dcl_pkg::STAT_PLACED &&
        out_data_i.load == dcl_pkg::LOAD_FIELD_W'(dcl_pkg::LOAD_MAX))
    else $error("saturated flag without a full bin");

endmodule

bind d_choice_least_loaded_insert dcl_checker u_dcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: dv/d_choice_least_loaded_insert_tb.sv
`timescale 1ns / 1ps

module d_choice_least_loaded_insert_tb;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  dcl_in_if  in_if ();
  dcl_out_if out_if ();
  dcl_cfg_if cfg_if ();

  d_choice_least_loaded_insert dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the block state
  dcl_pkg::load_t                     load_table [dcl_pkg::NUM_BINS];
  dcl_pkg::idx_t                      cand_ring [dcl_pkg::MAX_CHOICES];
  logic [1:0]                         ring_ptr;
  logic [2:0]                         ring_cnt;
  logic [dcl_pkg::BIN_COUNT_W-1:0]    cur_bin_count;
  logic [dcl_pkg::CHOICE_COUNT_W-1:0] cur_choice_count;
  logic                               cur_stream;

  dcl_pkg::item_t   item_queue [$];
  dcl_pkg::result_t pending_results [$];
  int               mismatch_count;
  logic             calm;

  function automatic int unsigned bin_limit();
    return (cur_bin_count < dcl_pkg::NUM_BINS) ? cur_bin_count : dcl_pkg::NUM_BINS;
  endfunction

  function automatic int choices_in_use();
    if (cur_choice_count == '0) begin
      return 1;
    end else if (cur_choice_count > dcl_pkg::MAX_CHOICES) begin
      return dcl_pkg::MAX_CHOICES;
    end
    return cur_choice_count;
  endfunction

  function automatic void note_register_write(dcl_pkg::cfg_reg_e idx,
                                              logic [dcl_pkg::CFG_DATA_W-1:0] val);
    unique case (idx)
      dcl_pkg::CFG_BIN_COUNT: begin
        cur_bin_count = val;
      end
      dcl_pkg::CFG_CHOICE_COUNT: begin
        cur_choice_count = val[dcl_pkg::CHOICE_COUNT_W-1:0];
        ring_ptr = '0;
        ring_cnt = '0;
      end
      dcl_pkg::CFG_STREAM_MODE: begin
        cur_stream = val[0];
        ring_ptr = '0;
        ring_cnt = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // expected result of one item (read, range error, priming or least-loaded placement), updates the shadow table
  function automatic dcl_pkg::result_t place_ball(dcl_pkg::item_t it);
    dcl_pkg::result_t r;
    int unsigned      lim;
    int               d;
    dcl_pkg::idx_t    cand [dcl_pkg::MAX_CHOICES];
    dcl_pkg::idx_t    best;
    r = '0;
    r.status = dcl_pkg::STAT_RANGE;
    lim = bin_limit();
    d = choices_in_use();
    if (it.action == dcl_pkg::ACT_READ) begin
      r.bin_index = it.read_index;
      if (it.read_index < lim) begin
        r.status = dcl_pkg::STAT_READ;
        r.load = load_table[it.read_index];
      end
      return r;
    end
    if (!cur_stream) begin
      cand = '{it.choice_0, it.choice_1, it.choice_2, it.choice_3};
    end else begin
      if (it.choice_0 >= lim) begin
        r.bin_index = it.choice_0;
        return r;
      end
      if (ring_ptr >= d) ring_ptr = '0;
      cand_ring[ring_ptr] = it.choice_0;
      ring_ptr = (int'(ring_ptr) + 1 >= d) ? 2'd0 : ring_ptr + 2'd1;
      if (ring_cnt < dcl_pkg::MAX_CHOICES) ring_cnt = ring_cnt + 3'd1;
      if (ring_cnt < d) begin
        r.status = dcl_pkg::STAT_PRIMING;
        r.bin_index = it.choice_0;
        return r;
      end
      cand = cand_ring;
    end
    // ring entries may be stale after bin_count shrank
    for (int i = 0; i < d; i++) begin
      if (cand[i] >= lim) begin
        r.bin_index = cand[i];
        return r;
      end
    end
    best = cand[0];
    for (int i = 1; i < d; i++) begin
      if (load_table[cand[i]] < load_table[best]) best = cand[i];
    end
    r.status = dcl_pkg::STAT_PLACED;
    r.bin_index = best;
    if (load_table[best] == dcl_pkg::LOAD_MAX) begin
      r.saturated = 1'b1;
    end else begin
      load_table[best] = load_table[best] + 1'b1;
    end
    r.load = load_table[best];
    return r;
  endfunction

  function automatic dcl_pkg::item_t insert_item(dcl_pkg::idx_t a, dcl_pkg::idx_t b,
                                                 dcl_pkg::idx_t c, dcl_pkg::idx_t e);
    dcl_pkg::item_t it;
    it.action = dcl_pkg::ACT_INSERT;
    it.choice_0 = a;
    it.choice_1 = b;
    it.choice_2 = c;
    it.choice_3 = e;
    it.read_index = dcl_pkg::idx_t'($urandom);
    return it;
  endfunction

  function automatic dcl_pkg::item_t read_item(dcl_pkg::idx_t r);
    dcl_pkg::item_t it;
    it = insert_item(dcl_pkg::idx_t'($urandom), dcl_pkg::idx_t'($urandom),
                     dcl_pkg::idx_t'($urandom), dcl_pkg::idx_t'($urandom));
    it.action = dcl_pkg::ACT_READ;
    it.read_index = r;
    return it;
  endfunction

  // mostly in range and crowded onto a few hot bins, now and then anything
  function automatic dcl_pkg::idx_t pick_bin();
    int unsigned lim;
    int unsigned roll;
    lim = bin_limit();
    roll = $urandom_range(99);
    if (lim == 0 || roll < 6) begin
      return dcl_pkg::idx_t'($urandom_range(4095));
    end else if (roll < 55) begin
      return dcl_pkg::idx_t'($urandom_range(((lim < 6) ? lim : 6) - 1));
    end
    return dcl_pkg::idx_t'($urandom_range(lim - 1));
  endfunction

  function automatic dcl_pkg::item_t random_item();
    dcl_pkg::item_t it;
    it = insert_item(pick_bin(), pick_bin(), pick_bin(), pick_bin());
    it.read_index = pick_bin();
    if ($urandom_range(99) < 20) it.action = dcl_pkg::ACT_READ;
    return it;
  endfunction

  task automatic add_item(dcl_pkg::item_t it);
    item_queue.insert(item_queue.size(), it);
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 10) $display("%t %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic wait_all_results();
    do @(negedge clk_i);
    while (item_queue.size() != 0 || in_if.valid || pending_results.size() != 0);
  endtask

  task automatic write_register(dcl_pkg::cfg_reg_e idx, logic [dcl_pkg::CFG_DATA_W-1:0] val);
    wait_all_results();
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    note_register_write(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_results.insert(pending_results.size(), place_ball(in_if.data));
      end
      if (!in_if.valid || in_if.ready) begin
        if (item_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= item_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    dcl_pkg::result_t got;
    dcl_pkg::result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d bin %0d load %0d sat %0b",
                                  got.status, got.bin_index, got.load, got.saturated));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.bin_index !== want.bin_index ||
              got.load !== want.load || got.saturated !== want.saturated) begin
            flag_mismatch($sformatf(
              "mismatch exp status %0d bin %0d load %0d sat %0b, got %0d %0d %0d %0b",
              want.status, want.bin_index, want.load, want.saturated,
              got.status, got.bin_index, got.load, got.saturated));
          end
        end
      end
      out_if.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  initial begin
    logic [dcl_pkg::BIN_COUNT_W-1:0] phase_counts [9];
    phase_counts = '{13'd4096, 13'd8191, 13'd16, 13'd4095, 13'd1, 13'd300, 13'd4096,
                     13'd2, dcl_pkg::BIN_COUNT_W'($urandom_range(4096, 1))};
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    calm = 1'b0;
    mismatch_count = 0;
    foreach (load_table[i]) load_table[i] = '0;
    foreach (cand_ring[i]) cand_ring[i] = '0;
    ring_ptr = '0;
    ring_cnt = '0;
    cur_bin_count = 13'd4096;
    cur_choice_count = 3'd2;
    cur_stream = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fresh mode, d = 2: ties go to the first slot
    add_item(insert_item(12'd0, 12'd4095, 12'd1, 12'd2));
    add_item(insert_item(12'd0, 12'd4095, 12'd3, 12'd4));
    add_item(insert_item(12'd4095, 12'd0, 12'hfff, 12'hfff));
    add_item(read_item(12'd0));
    add_item(read_item(12'd4095));
    // count above the maximum clamps to four
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd7);
    add_item(insert_item(12'd4095, 12'd0, 12'd2048, 12'd1365));
    add_item(insert_item(12'haaa, 12'h555, 12'd0, 12'd4095));
    // out of range candidates and reads
    write_register(dcl_pkg::CFG_BIN_COUNT, 13'd100);
    add_item(insert_item(12'd1, 12'd2, 12'd200, 12'd3));
    add_item(insert_item(12'd150, 12'd7, 12'd8, 12'd9));
    add_item(read_item(12'd100));
    add_item(read_item(12'd99));
    write_register(dcl_pkg::CFG_BIN_COUNT, 13'd0);
    add_item(read_item(12'd0));
    add_item(insert_item(12'd0, 12'd0, 12'd0, 12'd0));
    // bin count past the table size, count of zero acts as one
    write_register(dcl_pkg::CFG_BIN_COUNT, 13'd8191);
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd0);
    add_item(insert_item(12'd4095, 12'd0, 12'd0, 12'd0));
    // streamed ring, d = 3
    write_register(dcl_pkg::CFG_STREAM_MODE, 13'd1);
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd3);
    add_item(insert_item(12'd10, 12'd0, 12'd0, 12'd0));
    add_item(insert_item(12'd11, 12'hfff, 12'hfff, 12'hfff));
    add_item(insert_item(12'd12, 12'd5, 12'd6, 12'd7));
    add_item(insert_item(12'd13, 12'd5, 12'd6, 12'd7));
    add_item(read_item(12'd10));
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd2);
    add_item(insert_item(12'd50, 12'd0, 12'd0, 12'd0));
    add_item(insert_item(12'd60, 12'd0, 12'd0, 12'd0));
    // shrinking the bin count leaves a stale entry in the ring
    write_register(dcl_pkg::CFG_BIN_COUNT, 13'd55);
    add_item(insert_item(12'd10, 12'd0, 12'd0, 12'd0));
    add_item(insert_item(12'd70, 12'd0, 12'd0, 12'd0));
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd1);
    add_item(insert_item(12'd3, 12'd0, 12'd0, 12'd0));
    add_item(insert_item(12'd4095, 12'd0, 12'd0, 12'd0));

    write_register(dcl_pkg::CFG_STREAM_MODE, 13'd0);
    write_register(dcl_pkg::CFG_BIN_COUNT, 13'd4096);
    add_item(read_item(12'd4095));
    write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'd2);
    add_item(insert_item(12'd4095, 12'd4095, 12'd0, 12'd0));

    for (int ph = 0; ph < 9; ph++) begin
      write_register(dcl_pkg::CFG_BIN_COUNT, phase_counts[ph]);
      write_register(dcl_pkg::CFG_CHOICE_COUNT, 13'((ph * 3 + 1) % 8));
      write_register(dcl_pkg::CFG_STREAM_MODE, 13'(ph % 2));
      calm = (ph == 6);
      for (int n = 0; n < 125; n++) begin
        add_item(random_item());
        // let the block run dry mid-phase
        if (ph == 3 && n == 63) wait_all_results();
      end
    end
    wait_all_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
